### src/rsi_pkg.sv
// ============================================================================
// rsi_pkg: shared types and constants for the 2D ray/segment intersection block
// Fixed formats of the result and the register, plus the tag that rides along
// with each item through the ray parameter divider.
// ============================================================================
package rsi_pkg;

    // Width of the result ray parameter (unsigned Q16.16)
    localparam int QUOT_BITS = 32;
    // Fraction bits of the result
    localparam int FRAC_BITS = 16;
    // Width of the parallel threshold register
    localparam int THR_BITS = 32;
    // Reset value of the parallel threshold (about 1e-6 in units of 2^-32)
    localparam logic [THR_BITS-1:0] RESET_THRESHOLD = 32'd4295;

    // Decision bits carried beside the division
    typedef struct packed {
        logic hit;
        logic sat;
    } t_div_tag;

endpackage

### src/rsi_div_pipe.sv
// ============================================================================
// rsi_div_pipe: pipelined restoring divider for the ray parameter
// One quotient bit per stage, QUOT_BITS stages; the partial remainder must
// start below the denominator for the quotient to be valid.
// ============================================================================
module rsi_div_pipe #(
    parameter int DEN_W = 67
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  rsi_pkg::t_div_tag            i_tag,
    input  logic [DEN_W-1:0]             i_rem,
    input  logic [rsi_pkg::QUOT_BITS-1:0] i_low,
    input  logic [DEN_W-1:0]             i_den,
    output logic                         o_valid,
    output rsi_pkg::t_div_tag            o_tag,
    output logic [rsi_pkg::QUOT_BITS-1:0] o_quot
);
    import rsi_pkg::*;

    localparam int NS = QUOT_BITS;

    logic           r_valid [NS];
    t_div_tag       r_tag   [NS];
    logic [DEN_W-1:0] r_rem [NS];
    logic [DEN_W-1:0] r_den [NS];
    logic [NS-1:0]  r_low   [NS];
    logic [NS-1:0]  r_quot  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic             s_valid;
        t_div_tag         s_tag;
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [NS-1:0]    s_low;
        logic [NS-1:0]    s_quot;
        logic [DEN_W:0]   s_shift;
        logic [DEN_W:0]   s_diff;
        logic [DEN_W-1:0] n_rem;
        logic [NS-1:0]    n_quot;

        if (k == 0) begin : g_first
            assign s_valid = i_valid;
            assign s_tag   = i_tag;
            assign s_rem   = i_rem;
            assign s_den   = i_den;
            assign s_low   = i_low;
            assign s_quot  = '0;
        end else begin : g_next
            assign s_valid = r_valid[k-1];
            assign s_tag   = r_tag[k-1];
            assign s_rem   = r_rem[k-1];
            assign s_den   = r_den[k-1];
            assign s_low   = r_low[k-1];
            assign s_quot  = r_quot[k-1];
        end

        // bring down the next dividend bit, subtract when it fits
        always_comb begin
            s_shift = {s_rem, s_low[NS-1]};
            s_diff  = s_shift - {1'b0, s_den};
            if (!s_diff[DEN_W]) begin
                n_rem = s_diff[DEN_W-1:0];
            end else begin
                n_rem = s_shift[DEN_W-1:0];
            end
            n_quot = {s_quot[NS-2:0], ~s_diff[DEN_W]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k]  <= s_tag;
            r_rem[k]  <= n_rem;
            r_den[k]  <= s_den;
            r_low[k]  <= {s_low[NS-2:0], 1'b0};
            r_quot[k] <= n_quot;
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_tag   = r_tag[NS-1];
    assign o_quot  = r_quot[NS-1];

endmodule

### src/ray_segment_intersect_2d.sv
// ============================================================================
// ray_segment_intersect_2d: 2D ray against segment intersection test
// Pipeline: a result strobes on o_done after its item passes through
//   six arithmetic stages, 32 divider stages and one output register.
// Throughput: one item per cycle; busy never rises, every stage is pipelined.
// Reset clears all valid bits and loads the parallel threshold with 4295.
// ============================================================================
module ray_segment_intersect_2d #(
    parameter int COORD_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: parallel threshold
    input  logic                               i_cfg_we,
    input  logic [rsi_pkg::THR_BITS-1:0]       i_cfg_wdata,
    // command
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_BITS-1:0]       i_origin_x,
    input  logic signed [COORD_BITS-1:0]       i_origin_y,
    input  logic signed [COORD_BITS-1:0]       i_dir_x,
    input  logic signed [COORD_BITS-1:0]       i_dir_y,
    input  logic signed [COORD_BITS-1:0]       i_seg_start_x,
    input  logic signed [COORD_BITS-1:0]       i_seg_start_y,
    input  logic signed [COORD_BITS-1:0]       i_seg_end_x,
    input  logic signed [COORD_BITS-1:0]       i_seg_end_y,
    // result
    output logic                               o_done,
    output logic                               o_hit,
    output logic [rsi_pkg::QUOT_BITS-1:0]      o_ray_param,
    output logic                               o_saturated
);
    import rsi_pkg::*;

    // W: coordinate differences, H: low split of the second multiplier operand,
    // P: exact products, D: determinants (difference of two products)
    localparam int W = COORD_BITS + 1;
    localparam int H = (W + 1) / 2;
    localparam int P = 2 * W;
    localparam int D = P + 1;
    localparam int NPROD = 6;
    localparam int LATENCY = 6 + QUOT_BITS + 1;

    // ------------------------------------------------------------------
    // Threshold register
    // ------------------------------------------------------------------
    logic [THR_BITS-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= RESET_THRESHOLD;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // The pipeline never stalls, so an item is taken whenever start is high
    assign busy = 1'b0;

    logic s_accept;
    assign s_accept = start && !busy;

    // ------------------------------------------------------------------
    // Stage 1: A = O - S, B = E - S, keep D
    // ------------------------------------------------------------------
    logic                r_v1;
    logic signed [W-1:0] r_ax, r_ay, r_bx, r_by, r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        r_ax <= W'(i_origin_x) - W'(i_seg_start_x);
        r_ay <= W'(i_origin_y) - W'(i_seg_start_y);
        r_bx <= W'(i_seg_end_x) - W'(i_seg_start_x);
        r_by <= W'(i_seg_end_y) - W'(i_seg_start_y);
        r_dx <= W'(i_dir_x);
        r_dy <= W'(i_dir_y);
    end

    // ------------------------------------------------------------------
    // Stage 2: partial products. Each of the six products is split on its
    // second operand into an unsigned low half and a signed high half so
    // that no single multiplier grows past about W by H bits.
    // Products: by*dx, bx*dy (det), bx*ay, by*ax (num1), ay*dx, ax*dy (num2)
    // ------------------------------------------------------------------
    logic                      r_v2;
    logic signed [W-1:0]       s_opa [NPROD];
    logic signed [W-1:0]       s_opb [NPROD];
    logic signed [W+H:0]       r_pl  [NPROD];
    logic signed [2*W-H-1:0]   r_ph  [NPROD];

    always_comb begin
        s_opa[0] = r_by;  s_opb[0] = r_dx;
        s_opa[1] = r_bx;  s_opb[1] = r_dy;
        s_opa[2] = r_bx;  s_opb[2] = r_ay;
        s_opa[3] = r_by;  s_opb[3] = r_ax;
        s_opa[4] = r_ay;  s_opb[4] = r_dx;
        s_opa[5] = r_ax;  s_opb[5] = r_dy;
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NPROD; j++) begin
            r_pl[j] <= s_opa[j] * $signed({1'b0, s_opb[j][H-1:0]});
            r_ph[j] <= s_opa[j] * $signed(s_opb[j][W-1:H]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: recombine the partial products into exact products
    // ------------------------------------------------------------------
    logic                r_v3;
    logic signed [P-1:0] r_prod [NPROD];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NPROD; j++) begin
            r_prod[j] <= $signed({r_ph[j], {H{1'b0}}}) + P'(r_pl[j]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: determinants
    // ------------------------------------------------------------------
    logic                r_v4;
    logic signed [D-1:0] r_det, r_num1, r_num2;

    always_ff @(posedge i_clk) begin
        r_det  <= D'(r_prod[0]) - D'(r_prod[1]);
        r_num1 <= D'(r_prod[2]) - D'(r_prod[3]);
        r_num2 <= D'(r_prod[4]) - D'(r_prod[5]);
    end

    // ------------------------------------------------------------------
    // Stage 5: flip all three so that the determinant is nonnegative
    // ------------------------------------------------------------------
    logic         r_v5;
    logic         r_zero5;
    logic [D-1:0] r_det_abs, r_n1, r_n2;

    always_ff @(posedge i_clk) begin
        r_zero5 <= (r_det == '0);
        if (r_det[D-1]) begin
            r_det_abs <= -r_det;
            r_n1      <= -r_num1;
            r_n2      <= -r_num2;
        end else begin
            r_det_abs <= r_det;
            r_n1      <= r_num1;
            r_n2      <= r_num2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: decide hit and saturation, set up the division.
    // Hit: det nonzero and at least the threshold, num1 >= 0, 0 <= num2 <= det.
    // Saturate when t1 = num1*2^16/det reaches 2^32, i.e. num1 >= det*2^16;
    // otherwise the dividend's upper part num1>>16 starts below det and the
    // divider yields exactly 32 quotient bits.
    // ------------------------------------------------------------------
    logic                 s_hit6, s_sat6;
    logic                 r_v6;
    t_div_tag             r_tag6;
    logic [D-1:0]         r_rem6, r_den6;
    logic [QUOT_BITS-1:0] r_low6;

    always_comb begin
        s_hit6 = !r_zero5
              && (r_det_abs >= D'(r_thr))
              && !r_n1[D-1]
              && !r_n2[D-1]
              && (r_n2 <= r_det_abs);
        s_sat6 = {{FRAC_BITS{1'b0}}, r_n1} >= {r_det_abs, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_tag6.hit <= s_hit6;
        r_tag6.sat <= s_sat6;
        r_rem6     <= r_n1 >> (QUOT_BITS - FRAC_BITS);
        r_low6     <= {r_n1[FRAC_BITS-1:0], {(QUOT_BITS - FRAC_BITS){1'b0}}};
        r_den6     <= r_det_abs;
    end

    // Valid bits of the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= s_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // ------------------------------------------------------------------
    // Ray parameter divider
    // ------------------------------------------------------------------
    logic                 s_div_valid;
    t_div_tag             s_div_tag;
    logic [QUOT_BITS-1:0] s_div_quot;

    rsi_div_pipe #(
        .DEN_W (D)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_tag   (r_tag6),
        .i_rem   (r_rem6),
        .i_low   (r_low6),
        .i_den   (r_den6),
        .o_valid (s_div_valid),
        .o_tag   (s_div_tag),
        .o_quot  (s_div_quot)
    );

    // ------------------------------------------------------------------
    // Output register: zero the fields on a miss, clamp on saturation
    // ------------------------------------------------------------------
    logic                 r_done;
    logic                 r_hit;
    logic                 r_sat;
    logic [QUOT_BITS-1:0] r_ray_param;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= s_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= s_div_tag.hit;
        r_sat <= s_div_tag.hit && s_div_tag.sat;
        if (!s_div_tag.hit) begin
            r_ray_param <= '0;
        end else if (s_div_tag.sat) begin
            r_ray_param <= '1;
        end else begin
            r_ray_param <= s_div_quot;
        end
    end

    assign o_done      = r_done;
    assign o_hit       = r_hit;
    assign o_saturated = r_sat;
    assign o_ray_param = r_ray_param;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |-> ##LATENCY r_done)
        else $error("result strobe missing at fixed latency");

    a_sat_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |-> (o_hit && (o_ray_param == '1)))
        else $error("saturation without a clamped hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> ((o_ray_param == '0) && !o_saturated))
        else $error("miss with nonzero fields");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && !$past(r_v5)) |-> 1'b0)
        else $error("stage 6 valid without stage 5 item");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Testbench for ray_segment_intersect_2d
// Drives rays and segments through the command port, predicts every result
// with an exact wide-integer model of the intersection test, and checks each
// strobed result against the oldest prediction. Covers directed geometry,
// threshold edges and randomized aimed, noisy and near-parallel items.
// ============================================================================
module testbench;
    import rsi_pkg::*;

    localparam int          COORD_W     = 32;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          ITEMS_PER_PHASE = 86;

    // Handy Q16.16 values
    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] TWO     = 32'h0002_0000;
    localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

    typedef struct {
        logic [31:0] ox, oy, dx, dy, sx, sy, ex, ey;
    } t_ray_seg;

    typedef struct {
        logic                 hit;
        logic [QUOT_BITS-1:0] ray_param;
        logic                 sat;
    } t_crossing;

    // Clock, reset and every block input start at known values
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [THR_BITS-1:0] i_cfg_wdata = '0;
    logic start = 1'b0;
    logic busy;
    logic [COORD_W-1:0] i_origin_x = '0, i_origin_y = '0;
    logic [COORD_W-1:0] i_dir_x = '0, i_dir_y = '0;
    logic [COORD_W-1:0] i_seg_start_x = '0, i_seg_start_y = '0;
    logic [COORD_W-1:0] i_seg_end_x = '0, i_seg_end_y = '0;
    logic o_done, o_hit, o_saturated;
    logic [QUOT_BITS-1:0] o_ray_param;

    // Threshold as the block should currently hold it
    logic [THR_BITS-1:0] thr_model = RESET_THRESHOLD;
    t_crossing expected_crossings[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    // busy as seen just before each rising edge
    logic busy_seen = 1'b0;

    always #10 i_clk = ~i_clk;

    ray_segment_intersect_2d #(
        .COORD_BITS (COORD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_seg_start_x  (i_seg_start_x),
        .i_seg_start_y  (i_seg_start_y),
        .i_seg_end_x    (i_seg_end_x),
        .i_seg_end_y    (i_seg_end_y),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_ray_param    (o_ray_param),
        .o_saturated    (o_saturated)
    );

    // Exact intersection test: all determinants in 128-bit signed arithmetic,
    // wide enough that no product or difference can overflow.
    function automatic t_crossing predict_crossing(input t_ray_seg c,
                                                   input logic [THR_BITS-1:0] thr);
        logic signed [127:0] ax, ay, bx, by, dx, dy, det, num1, num2, quot;
        t_crossing r;
        r.hit = 1'b0;
        r.ray_param = '0;
        r.sat = 1'b0;
        ax = $signed(c.ox) - $signed(c.sx);
        ay = $signed(c.oy) - $signed(c.sy);
        bx = $signed(c.ex) - $signed(c.sx);
        by = $signed(c.ey) - $signed(c.sy);
        dx = $signed(c.dx);
        dy = $signed(c.dy);
        det  = by * dx - bx * dy;
        num1 = bx * ay - by * ax;
        num2 = ay * dx - ax * dy;
        // Exactly parallel is a miss even when the threshold is zero
        if (det == 0) return r;
        // Normalize to a positive determinant so t2 can be tested by magnitude
        if (det < 0) begin
            det  = -det;
            num1 = -num1;
            num2 = -num2;
        end
        if (det < $signed({96'd0, thr})) return r;
        // Behind the origin, or off either end of the segment
        if (num1 < 0 || num2 < 0 || num2 > det) return r;
        quot = (num1 <<< FRAC_BITS) / det;
        r.hit = 1'b1;
        if (quot[127:QUOT_BITS] != 0) begin
            r.ray_param = '1;
            r.sat = 1'b1;
        end else begin
            r.ray_param = quot[QUOT_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_ray_seg mk_item(input logic [31:0] ox, oy, dx, dy,
                                         input logic [31:0] sx, sy, ex, ey);
        t_ray_seg c;
        c.ox = ox; c.oy = oy; c.dx = dx; c.dy = dy;
        c.sx = sx; c.sy = sy; c.ex = ex; c.ey = ey;
        return c;
    endfunction

    // Random signed coordinate limited to a magnitude of about 2^(bits-1)
    function automatic logic [31:0] rand_coord(input int unsigned bits);
        return $signed($urandom) >>> (32 - bits);
    endfunction

    // Rays aimed at a point on the segment, with random content, and also noise,
    // origin-on-endpoint, near-parallel, behind-the-origin and saturating cases.
    function automatic t_ray_seg random_ray_seg();
        int unsigned kind, bits, f, sh;
        longint sx, sy, ex, ey, ox, oy, px, py, dxl, dyl;
        t_ray_seg c;
        kind = $urandom_range(0, 99);
        bits = $urandom_range(4, 29);
        if (kind < 15) begin
            return mk_item($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
        end
        sx = $signed(rand_coord(bits));
        sy = $signed(rand_coord(bits));
        ex = $signed(rand_coord(bits));
        ey = $signed(rand_coord(bits));
        ox = $signed(rand_coord(bits));
        oy = $signed(rand_coord(bits));
        // Aim at an endpoint now and then, else anywhere along the segment
        if (kind < 25) f = ($urandom_range(0, 1) != 0) ? 0 : 256;
        else f = $urandom_range(0, 256);
        px = sx + (((ex - sx) * longint'(f)) >>> 8);
        py = sy + (((ey - sy) * longint'(f)) >>> 8);
        dxl = px - ox;
        dyl = py - oy;
        if (kind < 35) begin
            // origin sits on the segment's first endpoint
            ox = sx;
            oy = sy;
            dxl = $signed(rand_coord(bits));
            dyl = $signed(rand_coord(bits));
        end else if (kind < 45) begin
            // short direction pushes t1 toward the top of the output range or past it
            sh = $urandom_range(12, 24);
            dxl = dxl >>> sh;
            dyl = dyl >>> sh;
        end else if (kind < 55) begin
            // direction along the segment, nudged by a few LSBs
            sh = $urandom_range(0, 20);
            dxl = ((ex - sx) >>> sh) + longint'($urandom_range(0, 4)) - 2;
            dyl = ((ey - sy) >>> sh) + longint'($urandom_range(0, 4)) - 2;
        end else if (kind < 65) begin
            // pointing away from the segment
            dxl = -dxl;
            dyl = -dyl;
        end else begin
            sh = $urandom_range(0, 4);
            dxl = dxl >>> sh;
            dyl = dyl >>> sh;
        end
        c.ox = 32'(ox); c.oy = 32'(oy);
        c.dx = 32'(dxl); c.dy = 32'(dyl);
        c.sx = 32'(sx); c.sy = 32'(sy);
        c.ex = 32'(ex); c.ey = 32'(ey);
        return c;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        busy_seen = busy;
    end

    // Result checker: sample mid-cycle, while the strobed result is stable
    always @(negedge i_clk) begin
        t_crossing exp_c;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_crossings.size() == 0) begin
                $display("%0t: unexpected result hit=%0b ray_param=%h saturated=%0b",
                         $time, o_hit, o_ray_param, o_saturated);
                mismatch_count++;
            end else begin
                exp_c = expected_crossings.pop_front();
                if (o_hit !== exp_c.hit) begin
                    $display("%0t: hit expected %0b, actual %0b",
                             $time, exp_c.hit, o_hit);
                    mismatch_count++;
                end
                if (o_ray_param !== exp_c.ray_param) begin
                    $display("%0t: ray_param expected %h, actual %h",
                             $time, exp_c.ray_param, o_ray_param);
                    mismatch_count++;
                end
                if (o_saturated !== exp_c.sat) begin
                    $display("%0t: saturated expected %0b, actual %0b",
                             $time, exp_c.sat, o_saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one item. The sender runs in bursts: at the end of each burst,
    // drop start for a random gap, if any, then pick the next burst length.
    task automatic send_item(input t_ray_seg item);
        int unsigned gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 5))
                0, 1: gap = 0;
                2:    gap = $urandom_range(30, 60);
                default: gap = $urandom_range(1, 12);
            endcase
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_origin_x    <= item.ox;
        i_origin_y    <= item.oy;
        i_dir_x       <= item.dx;
        i_dir_y       <= item.dy;
        i_seg_start_x <= item.sx;
        i_seg_start_y <= item.sy;
        i_seg_end_x   <= item.ex;
        i_seg_end_y   <= item.ey;
        start         <= 1'b1;
        // Hold the item until an edge with busy low takes it
        @(posedge i_clk);
        while (busy_seen) @(posedge i_clk);
        expected_crossings.push_back(predict_crossing(item, thr_model));
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain_crossings();
        start <= 1'b0;
        burst_left = 0;
        while (expected_crossings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the threshold; call only with the pipeline empty
    task automatic write_threshold(input logic [THR_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        thr_model = value;
        @(posedge i_clk);
    endtask

    // Hand-built geometry under the reset threshold
    task automatic test_directed_geometry();
        // plain crossing at t1 = 2
        send_item(mk_item(0, 0, ONE, 0, TWO, NEG_ONE, TWO, ONE));
        // segment ends exactly on the ray: t2 = 0 and t2 = 1
        send_item(mk_item(0, 0, ONE, 0, TWO, 0, TWO, ONE));
        send_item(mk_item(0, 0, ONE, 0, TWO, NEG_ONE, TWO, 0));
        // origin on the segment line: t1 = 0
        send_item(mk_item(TWO, 0, ONE, 0, TWO, NEG_ONE, TWO, ONE));
        // ray pointing away
        send_item(mk_item(0, 0, NEG_ONE, 0, TWO, NEG_ONE, TWO, ONE));
        // direction along the segment: zero determinant
        send_item(mk_item(0, 0, 0, ONE, TWO, NEG_ONE, TWO, ONE));
        // tiny positive t1 truncates to zero
        send_item(mk_item(32'h0001_FFFF, 0, MOST_POS, 0, TWO, NEG_ONE, TWO, ONE));
        // one-LSB direction: t1 far out of range
        send_item(mk_item(0, 0, 1, 0, TWO, NEG_ONE, TWO, ONE));
        // determinant right at the reset threshold, then one below it
        send_item(mk_item(0, 0, 32'd4295, 0, TWO, 0, TWO, 1));
        send_item(mk_item(0, 0, 32'd4294, 0, TWO, 0, TWO, 1));
        // field extremes
        send_item(mk_item(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
                          MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));
        send_item(mk_item(MOST_POS, MOST_POS, MOST_POS, MOST_POS,
                          MOST_POS, MOST_POS, MOST_POS, MOST_POS));
        send_item(mk_item(MOST_NEG, MOST_NEG, MOST_POS, MOST_POS,
                          MOST_POS, MOST_NEG, MOST_NEG, MOST_POS));
        send_item(mk_item(MOST_POS, MOST_NEG, MOST_NEG, MOST_POS,
                          MOST_NEG, MOST_NEG, MOST_POS, MOST_POS));
        send_item(mk_item(MOST_NEG, MOST_POS, MOST_POS, MOST_NEG,
                          MOST_POS, MOST_POS, MOST_NEG, MOST_NEG));
        // segment stops one LSB short of the ray
        send_item(mk_item(0, 0, ONE, 0, TWO, NEG_ONE, TWO, 32'hFFFF_FFFF));
        // degenerate segment, both endpoints equal
        send_item(mk_item(0, 0, ONE, 0, TWO, ONE, TWO, ONE));
        // endpoints swapped: negative determinant
        send_item(mk_item(0, 0, ONE, 0, TWO, ONE, TWO, NEG_ONE));
        drain_crossings();
    endtask

    // Threshold at zero, one and all ones
    task automatic test_threshold_edges();
        write_threshold('0);
        send_item(mk_item(0, 0, 0, ONE, TWO, NEG_ONE, TWO, ONE));
        send_item(mk_item(0, 0, 1, 0, TWO, 0, TWO, 1));
        drain_crossings();
        write_threshold(32'd1);
        send_item(mk_item(0, 0, 1, 0, TWO, 0, TWO, 1));
        send_item(mk_item(0, 0, 0, ONE, TWO, NEG_ONE, TWO, ONE));
        drain_crossings();
        write_threshold('1);
        // determinant exactly 2^32-1, then 2^32-2^16, then 2^33
        send_item(mk_item(0, 0, 32'h0000_FFFF, 0, TWO, 0, TWO, 32'h0001_0001));
        send_item(mk_item(0, 0, 32'h0000_FFFF, 0, TWO, 0, TWO, ONE));
        send_item(mk_item(0, 0, ONE, 0, TWO, NEG_ONE, TWO, ONE));
        drain_crossings();
    endtask

    // Random items across several threshold settings
    task automatic test_random_geometry();
        logic [THR_BITS-1:0] thr_list[7];
        thr_list[0] = RESET_THRESHOLD;
        thr_list[1] = '0;
        thr_list[2] = $urandom;
        thr_list[3] = $urandom_range(0, 1 << 20);
        thr_list[4] = '1;
        thr_list[5] = 32'd1;
        thr_list[6] = RESET_THRESHOLD;
        foreach (thr_list[p]) begin
            write_threshold(thr_list[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_item(random_ray_seg());
                // in the third phase, pause midway until the pipeline runs dry
                if (p == 2 && i == 40) drain_crossings();
            end
            drain_crossings();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_geometry();
        test_threshold_edges();
        test_random_geometry();
        // Wait out the pipeline once more for any stray result
        drain_crossings();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
